/* design/mlr_pkg.sv */
package mlr_pkg;

  // Command codes carried on the opcode field
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_NEXT = 1'b1;

  // Octant class of a loaded line
  typedef enum logic [1:0] {
    SLOPE_STEEP_UP     = 2'd0,
    SLOPE_SHALLOW_UP   = 2'd1,
    SLOPE_SHALLOW_DOWN = 2'd2,
    SLOPE_STEEP_DOWN   = 2'd3
  } slope_t;

  // Control part of a classified word on its way to the stepper
  typedef struct packed {
    logic   is_load;
    slope_t slope;
  } cmd_ctrl_t;

  // Extra bits the decision term needs over a coordinate
  localparam int unsigned DEC_EXTRA = 3;

endpackage

/* design/mlr_front.sv */
module mlr_front #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                                          opcode,
  input  logic [COORD_BITS-1:0]                         x_start,
  input  logic [COORD_BITS-1:0]                         y_start,
  input  logic [COORD_BITS-1:0]                         x_end,
  input  logic [COORD_BITS-1:0]                         y_end,
  output mlr_pkg::cmd_ctrl_t                            ctrl,
  output logic [COORD_BITS-1:0]                         first_x,
  output logic [COORD_BITS-1:0]                         first_y,
  output logic [COORD_BITS-1:0]                         steps,
  output logic signed [COORD_BITS+mlr_pkg::DEC_EXTRA-1:0] decision,
  output logic signed [COORD_BITS+mlr_pkg::DEC_EXTRA-1:0] inc_a,
  output logic signed [COORD_BITS+mlr_pkg::DEC_EXTRA-1:0] inc_b
);

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned DW = COORD_BITS + mlr_pkg::DEC_EXTRA;

  logic signed [CW:0]   dx;
  logic signed [CW:0]   dy;
  logic [CW-1:0]        adx;
  logic [CW-1:0]        ady;
  logic                 opposite;
  logic                 steep;
  logic                 swap;
  logic [CW-1:0]        dmaj;
  logic [CW-1:0]        dmin;
  logic signed [DW-1:0] maj_ext;
  logic signed [DW-1:0] min2_ext;
  mlr_pkg::slope_t      slope;

  // Signed deltas and their magnitudes
  assign dx  = signed'({1'b0, x_end}) - signed'({1'b0, x_start});
  assign dy  = signed'({1'b0, y_end}) - signed'({1'b0, y_start});
  assign adx = dx[CW] ? CW'(-dx) : dx[CW-1:0];
  assign ady = dy[CW] ? CW'(-dy) : dy[CW-1:0];

  assign opposite = (dx[CW] && !dy[CW] && (dy != '0)) ||
                    (dy[CW] && !dx[CW] && (dx != '0));
  assign steep    = ady > adx;

  // Pick the octant and which endpoint starts the walk
  always_comb begin
    if (steep) begin
      dmaj = ady;
      dmin = adx;
      if (!opposite) begin
        slope = mlr_pkg::SLOPE_STEEP_UP;
        swap  = y_start > y_end;
      end else begin
        slope = mlr_pkg::SLOPE_STEEP_DOWN;
        swap  = y_start < y_end;
      end
    end else begin
      dmaj  = adx;
      dmin  = ady;
      slope = opposite ? mlr_pkg::SLOPE_SHALLOW_DOWN : mlr_pkg::SLOPE_SHALLOW_UP;
      swap  = x_start > x_end;
    end
  end

  assign first_x = swap ? x_end : x_start;
  assign first_y = swap ? y_end : y_start;
  assign steps   = dmaj;

  // Decision term 2*dmin - dmaj, sign set by the octant, and its step increments
  assign maj_ext  = signed'({{(DW-CW){1'b0}}, dmaj});
  assign min2_ext = signed'({{(DW-CW-1){1'b0}}, dmin, 1'b0});
  assign inc_a    = min2_ext;
  assign inc_b    = (maj_ext - signed'({{(DW-CW){1'b0}}, dmin})) <<< 1;

  always_comb begin
    if (slope == mlr_pkg::SLOPE_STEEP_UP || slope == mlr_pkg::SLOPE_SHALLOW_DOWN) begin
      decision = min2_ext - maj_ext;
    end else begin
      decision = maj_ext - min2_ext;
    end
  end

  assign ctrl.is_load = (opcode == mlr_pkg::OP_LOAD);
  assign ctrl.slope   = slope;

endmodule

/* design/mlr_queue.sv */
module mlr_queue #(
  parameter int unsigned DATA_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  mlr_pkg::cmd_ctrl_t       push_ctrl,
  input  logic [DATA_BITS-1:0]     push_data,
  output logic                     full,
  output logic                     head_valid,
  output mlr_pkg::cmd_ctrl_t       head_ctrl,
  output logic [DATA_BITS-1:0]     head_data,
  input  logic                     pop
);

  localparam int unsigned DEPTH  = 4;
  localparam int unsigned PTR_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = PTR_W + 1;

  mlr_pkg::cmd_ctrl_t   ctrl_mem [DEPTH];
  logic [DATA_BITS-1:0] data_mem [DEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [CNT_W-1:0]     count;
  logic                 do_push;
  logic                 do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;
  assign head_ctrl  = ctrl_mem[rd_ptr];
  assign head_data  = data_mem[rd_ptr];

  // Store incoming words
  always_ff @(posedge clk) begin
    if (do_push) begin
      ctrl_mem[wr_ptr] <= push_ctrl;
      data_mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

/* design/mlr_back.sv */
module mlr_back #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          head_valid,
  input  mlr_pkg::cmd_ctrl_t                            head_ctrl,
  input  logic [COORD_BITS-1:0]                         first_x,
  input  logic [COORD_BITS-1:0]                         first_y,
  input  logic [COORD_BITS-1:0]                         steps,
  input  logic signed [COORD_BITS+mlr_pkg::DEC_EXTRA-1:0] decision_init,
  input  logic signed [COORD_BITS+mlr_pkg::DEC_EXTRA-1:0] inc_a_in,
  input  logic signed [COORD_BITS+mlr_pkg::DEC_EXTRA-1:0] inc_b_in,
  output logic                                          pop,
  output logic                                          pix_valid,
  input  logic                                          pix_stall,
  output logic [COORD_BITS-1:0]                         pixel_x,
  output logic [COORD_BITS-1:0]                         pixel_y,
  output logic                                          last
);

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned DW = COORD_BITS + mlr_pkg::DEC_EXTRA;

  logic [CW-1:0]        cur_x;
  logic [CW-1:0]        cur_y;
  logic [CW-1:0]        steps_left;
  logic signed [DW-1:0] decision;
  logic signed [DW-1:0] inc_a;
  logic signed [DW-1:0] inc_b;
  mlr_pkg::slope_t      slope_case;
  logic                 active;

  logic [CW-1:0]        cur_x_next;
  logic [CW-1:0]        cur_y_next;
  logic signed [DW-1:0] decision_next;
  logic                 out_free;
  logic                 do_load;
  logic                 emit;
  logic                 dec_neg;
  logic                 dec_zero;

  assign out_free = !pix_valid || !pix_stall;
  assign pop      = head_valid && (head_ctrl.is_load || !active || out_free);
  assign do_load  = head_valid && head_ctrl.is_load;
  assign emit     = head_valid && !head_ctrl.is_load && active && out_free;
  assign dec_neg  = decision[DW-1];
  assign dec_zero = (decision == '0);

  // One midpoint step in the current octant
  always_comb begin
    cur_x_next    = cur_x;
    cur_y_next    = cur_y;
    decision_next = decision;
    case (slope_case)
      mlr_pkg::SLOPE_STEEP_UP: begin
        cur_y_next = cur_y + CW'(1);
        if (!dec_neg) begin
          cur_x_next    = cur_x + CW'(1);
          decision_next = decision - inc_b;
        end else begin
          decision_next = decision + inc_a;
        end
      end
      mlr_pkg::SLOPE_SHALLOW_UP: begin
        cur_x_next = cur_x + CW'(1);
        if (dec_neg) begin
          cur_y_next    = cur_y + CW'(1);
          decision_next = decision + inc_b;
        end else begin
          decision_next = decision - inc_a;
        end
      end
      mlr_pkg::SLOPE_SHALLOW_DOWN: begin
        cur_x_next = cur_x + CW'(1);
        if (!dec_neg && !dec_zero) begin
          cur_y_next    = cur_y - CW'(1);
          decision_next = decision - inc_b;
        end else begin
          decision_next = decision + inc_a;
        end
      end
      mlr_pkg::SLOPE_STEEP_DOWN: begin
        cur_y_next = cur_y - CW'(1);
        if (dec_neg) begin
          cur_x_next    = cur_x + CW'(1);
          decision_next = decision + inc_b;
        end else begin
          decision_next = decision - inc_a;
        end
      end
      default: begin
        cur_x_next = cur_x;
      end
    endcase
  end

  // Line state: load a new line or walk one pixel
  always_ff @(posedge clk) begin
    if (do_load) begin
      cur_x      <= first_x;
      cur_y      <= first_y;
      steps_left <= steps;
      decision   <= decision_init;
      inc_a      <= inc_a_in;
      inc_b      <= inc_b_in;
      slope_case <= head_ctrl.slope;
    end else if (emit) begin
      cur_x      <= cur_x_next;
      cur_y      <= cur_y_next;
      steps_left <= steps_left - CW'(1);
      decision   <= decision_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (do_load) begin
      active <= (steps != '0);
    end else if (emit) begin
      active <= (steps_left != CW'(1));
    end
  end

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (emit) begin
      pix_valid <= 1'b1;
    end else if (!pix_stall) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_x <= cur_x;
      pixel_y <= cur_y;
      last    <= (steps_left == CW'(1));
    end
  end

endmodule

/* design/midpoint_line_rasterizer.sv */
// Midpoint line rasterizer. A load word (opcode 0) sets up a line between two
// endpoints and emits nothing; each next word (opcode 1) emits one pixel, with
// last set on the final one. The endpoint at which the walk stops is never
// drawn, a line with equal endpoints has no pixels, and a next word with no
// line active is dropped. A load replaces any line still in progress. Words
// are classified in the front end, pass a four-entry queue and are carried
// out by the stepper, which retires one word per clock unless a next word
// waits on a stalled output: a pixel comes out every cycle while the output
// is not stalled, and each word is written into the queue and its pixel
// goes into the output register once the word reaches the head. The input
// stalls only when the queue is full.
module midpoint_line_rasterizer #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  logic                  opcode,
  input  logic [COORD_BITS-1:0] x_start,
  input  logic [COORD_BITS-1:0] y_start,
  input  logic [COORD_BITS-1:0] x_end,
  input  logic [COORD_BITS-1:0] y_end,
  output logic                  pix_valid,
  input  logic                  pix_stall,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y,
  output logic                  last
);

  localparam int unsigned CW     = COORD_BITS;
  localparam int unsigned DW     = COORD_BITS + mlr_pkg::DEC_EXTRA;
  localparam int unsigned DATA_W = 3 * CW + 3 * DW;

  mlr_pkg::cmd_ctrl_t   f_ctrl;
  logic [CW-1:0]        f_x;
  logic [CW-1:0]        f_y;
  logic [CW-1:0]        f_steps;
  logic signed [DW-1:0] f_dec;
  logic signed [DW-1:0] f_inc_a;
  logic signed [DW-1:0] f_inc_b;
  logic [DATA_W-1:0]    f_data;

  logic                 q_full;
  logic                 q_valid;
  mlr_pkg::cmd_ctrl_t   q_ctrl;
  logic [DATA_W-1:0]    q_data;
  logic                 q_pop;

  mlr_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .opcode  (opcode),
    .x_start (x_start),
    .y_start (y_start),
    .x_end   (x_end),
    .y_end   (y_end),
    .ctrl    (f_ctrl),
    .first_x (f_x),
    .first_y (f_y),
    .steps   (f_steps),
    .decision(f_dec),
    .inc_a   (f_inc_a),
    .inc_b   (f_inc_b)
  );

  // Pack the classified word for the queue
  assign f_data = {f_x, f_y, f_steps, f_dec, f_inc_a, f_inc_b};

  mlr_queue #(
    .DATA_BITS(DATA_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_valid),
    .push_ctrl (f_ctrl),
    .push_data (f_data),
    .full      (q_full),
    .head_valid(q_valid),
    .head_ctrl (q_ctrl),
    .head_data (q_data),
    .pop       (q_pop)
  );

  assign cmd_stall = q_full;

  mlr_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (q_valid),
    .head_ctrl    (q_ctrl),
    .first_x      (q_data[DATA_W-1 -: CW]),
    .first_y      (q_data[DATA_W-CW-1 -: CW]),
    .steps        (q_data[DATA_W-2*CW-1 -: CW]),
    .decision_init(signed'(q_data[3*DW-1 -: DW])),
    .inc_a_in     (signed'(q_data[2*DW-1 -: DW])),
    .inc_b_in     (signed'(q_data[DW-1:0])),
    .pop          (q_pop),
    .pix_valid    (pix_valid),
    .pix_stall    (pix_stall),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .last         (last)
  );

endmodule
